### rtl/vector3_alu_assert.svh
// Assertion shorthands shared by the vector unit's modules.
// Both expect a clock named clk in scope; V3A_CHECK also expects an active-low reset named arst_n.
`ifndef VECTOR3_ALU_ASSERT_SVH
`define VECTOR3_ALU_ASSERT_SVH

// Checked only while the block is out of reset.
`define V3A_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define V3A_CHECK_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/v3a_pkg.sv
package v3a_pkg;

	localparam logic [3:0] CMD_ADD    = 4'd0;
	localparam logic [3:0] CMD_SUB    = 4'd1;
	localparam logic [3:0] CMD_MULV   = 4'd2;
	localparam logic [3:0] CMD_SCALE  = 4'd3;
	localparam logic [3:0] CMD_DIV    = 4'd4;
	localparam logic [3:0] CMD_MAG    = 4'd5;
	localparam logic [3:0] CMD_MAGSQ  = 4'd6;
	localparam logic [3:0] CMD_DIST   = 4'd7;
	localparam logic [3:0] CMD_DISTSQ = 4'd8;
	localparam logic [3:0] CMD_NORM   = 4'd9;
	localparam logic [3:0] CMD_DOT    = 4'd10;
	localparam logic [3:0] CMD_CROSS  = 4'd11;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;
	localparam logic [1:0] ST_ZERO = 2'd3;

	localparam logic [31:0] Q_MAX = 32'h7fff_ffff;
	localparam logic [31:0] Q_MIN = 32'h8000_0000;

	// Square root: 32 result bits, SQ_STEPS per register stage.
	localparam int SQ_BITS   = 32;
	localparam int SQ_STEPS  = 4;
	localparam int SQ_STAGES = SQ_BITS / SQ_STEPS;

	// Divider: 48 quotient bits (|A| shifted up by 16), DV_STEPS per stage.
	localparam int DV_BITS   = 48;
	localparam int DV_STEPS  = 4;
	localparam int DV_STAGES = DV_BITS / DV_STEPS;

	typedef logic [2:0][31:0] vec_t;

	// Everything an item carries down the pipeline.
	typedef struct packed {
		logic [3:0]  cmd;
		vec_t        a;
		logic [31:0] s;
		vec_t        v;
		logic [31:0] sca;
		logic        sat;
		logic        zv;
	} ctx_t;

	typedef struct packed {
		logic [31:0] v;
		logic        sat;
	} sv_t;

	// Round a Q32.32 value to Q16.16 (nearest, ties upward) and clamp.
	function automatic sv_t rnd_sat(input logic signed [65:0] t);
		logic signed [65:0] r;
		sv_t o;
		r = (t + 66'sd32768) >>> 16;
		if (r > 66'sd2147483647) begin
			o.v   = Q_MAX;
			o.sat = 1'b1;
		end else if (r < -66'sd2147483648) begin
			o.v   = Q_MIN;
			o.sat = 1'b1;
		end else begin
			o.v   = r[31:0];
			o.sat = 1'b0;
		end
		return o;
	endfunction

endpackage

### rtl/v3a_prod.sv
module v3a_prod import v3a_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  logic [3:0]  cmd,
	input  vec_t        a,
	input  vec_t        b,
	input  logic [31:0] s,
	output logic        out_vld,
	output ctx_t        out_ctx,
	output logic [63:0] out_sumsq
);

	logic [2:0][32:0] d;
	logic [2:0][32:0] sum;
	logic [2:0][32:0] as_r;
	vec_t             as_v;
	logic             as_sat;
	logic             big;
	logic [31:0]      x [3];
	logic [31:0]      y [3];
	logic [31:0]      u [3];
	logic [31:0]      w [3];
	ctx_t             ctx1;

	logic        vld_s1, vld_s2, vld_s3;
	ctx_t        ctx_s1, ctx_s2, ctx_s3;
	logic        big_s1, big_s2;
	logic [31:0] x_s1 [3];
	logic [31:0] y_s1 [3];
	logic [31:0] u_s1 [3];
	logic [31:0] w_s1 [3];
	logic signed [63:0] m_s2 [3];
	logic signed [63:0] n_s2 [3];
	logic [63:0] sumsq_s3;

	// Stage 1: differences, add/sub with clamping, multiplier operand select.
	always_comb begin
		big    = 1'b0;
		as_sat = 1'b0;
		for (int i = 0; i < 3; i++) begin
			d[i]   = {a[i][31], a[i]} - {b[i][31], b[i]};
			sum[i] = {a[i][31], a[i]} + {b[i][31], b[i]};
			if (d[i][32] != d[i][31]) big = 1'b1;
			as_r[i] = (cmd == CMD_SUB) ? d[i] : sum[i];
			if (as_r[i][32] != as_r[i][31]) begin
				as_v[i] = as_r[i][32] ? Q_MIN : Q_MAX;
				as_sat  = 1'b1;
			end else begin
				as_v[i] = as_r[i][31:0];
			end
		end
	end

	for (genvar g = 0; g < 3; g++) begin : g_opnd
		localparam int J1 = (g + 1) % 3;
		localparam int J2 = (g + 2) % 3;
		always_comb begin
			x[g] = a[g];
			y[g] = b[g];
			u[g] = '0;
			w[g] = '0;
			unique case (cmd) inside
				CMD_SCALE: y[g] = s;
				CMD_MAG, CMD_MAGSQ, CMD_NORM: y[g] = a[g];
				CMD_DIST, CMD_DISTSQ: begin
					x[g] = d[g][31:0];
					y[g] = d[g][31:0];
				end
				CMD_CROSS: begin
					x[g] = a[J1];
					y[g] = b[J2];
					u[g] = a[J2];
					w[g] = b[J1];
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		ctx1.cmd = cmd;
		ctx1.a   = a;
		ctx1.s   = s;
		ctx1.sca = '0;
		ctx1.zv  = 1'b0;
		if (cmd == CMD_ADD || cmd == CMD_SUB) begin
			ctx1.v   = as_v;
			ctx1.sat = as_sat;
		end else begin
			ctx1.v   = '0;
			ctx1.sat = 1'b0;
		end
	end

	// Stage 3: rounding and clamping of products and sums of products.
	logic [63:0]        sumsq;
	logic signed [65:0] dsum;
	sv_t                rv [3];
	sv_t                dv;
	logic [64:0]        msq;
	logic               msq_sat;
	ctx_t               ctx3;

	always_comb begin
		sumsq = m_s2[0] + m_s2[1] + m_s2[2];
		dsum  = $signed({{2{m_s2[0][63]}}, m_s2[0]}) + $signed({{2{m_s2[1][63]}}, m_s2[1]})
			+ $signed({{2{m_s2[2][63]}}, m_s2[2]});
		for (int i = 0; i < 3; i++) begin
			if (ctx_s2.cmd == CMD_CROSS)
				rv[i] = rnd_sat($signed({{2{m_s2[i][63]}}, m_s2[i]})
					- $signed({{2{n_s2[i][63]}}, n_s2[i]}));
			else
				rv[i] = rnd_sat($signed({{2{m_s2[i][63]}}, m_s2[i]}));
		end
		dv      = rnd_sat(dsum);
		msq     = ({1'b0, sumsq} + 65'h8000) >> 16;
		msq_sat = |msq[64:31];

		ctx3 = ctx_s2;
		case (ctx_s2.cmd) inside
			CMD_MULV, CMD_SCALE, CMD_CROSS: begin
				for (int i = 0; i < 3; i++) ctx3.v[i] = rv[i].v;
				ctx3.sat = rv[0].sat | rv[1].sat | rv[2].sat;
			end
			CMD_DOT: begin
				ctx3.sca = dv.v;
				ctx3.sat = dv.sat;
			end
			CMD_MAGSQ, CMD_DISTSQ: begin
				if (ctx_s2.cmd == CMD_DISTSQ && big_s2) begin
					ctx3.sca = Q_MAX;
					ctx3.sat = 1'b1;
				end else begin
					ctx3.sca = msq_sat ? Q_MAX : msq[31:0];
					ctx3.sat = msq_sat;
				end
			end
			CMD_DIST: begin
				if (big_s2) begin
					ctx3.sca = Q_MAX;
					ctx3.sat = 1'b1;
				end
			end
			CMD_NORM: ctx3.zv = (sumsq == 64'd0);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ctx_s1   <= ctx1;
			big_s1   <= big;
			ctx_s2   <= ctx_s1;
			big_s2   <= big_s1;
			ctx_s3   <= ctx3;
			sumsq_s3 <= sumsq;
			for (int i = 0; i < 3; i++) begin
				x_s1[i] <= x[i];
				y_s1[i] <= y[i];
				u_s1[i] <= u[i];
				w_s1[i] <= w[i];
				m_s2[i] <= $signed(x_s1[i]) * $signed(y_s1[i]);
				n_s2[i] <= $signed(u_s1[i]) * $signed(w_s1[i]);
			end
		end
	end

	assign out_vld   = vld_s3;
	assign out_ctx   = ctx_s3;
	assign out_sumsq = sumsq_s3;

endmodule

### rtl/v3a_sqrt.sv
`include "vector3_alu_assert.svh"

module v3a_sqrt import v3a_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        en,
	input  logic        in_vld,
	input  ctx_t        in_ctx,
	input  logic [63:0] in_rad,
	output logic        out_vld,
	output ctx_t        out_ctx,
	output logic [31:0] out_root
);

	logic        vld_s  [SQ_STAGES];
	ctx_t        ctx_s  [SQ_STAGES];
	logic [63:0] rad_s  [SQ_STAGES];
	logic [35:0] rem_s  [SQ_STAGES];
	logic [31:0] root_s [SQ_STAGES];

	for (genvar g = 0; g < SQ_STAGES; g++) begin : g_stage
		logic        src_vld;
		ctx_t        src_ctx;
		logic [63:0] src_rad, nx_rad;
		logic [35:0] src_rem, nx_rem;
		logic [31:0] src_root, nx_root;

		if (g == 0) begin : g_first
			assign src_vld  = in_vld;
			assign src_ctx  = in_ctx;
			assign src_rad  = in_rad;
			assign src_rem  = '0;
			assign src_root = '0;
		end else begin : g_next
			assign src_vld  = vld_s[g-1];
			assign src_ctx  = ctx_s[g-1];
			assign src_rad  = rad_s[g-1];
			assign src_rem  = rem_s[g-1];
			assign src_root = root_s[g-1];
		end

		// Two radicand bits in, one root bit out per step.
		always_comb begin
			nx_rad  = src_rad;
			nx_rem  = src_rem;
			nx_root = src_root;
			for (int k = 0; k < SQ_STEPS; k++) begin
				nx_rem = {nx_rem[33:0], nx_rad[63:62]};
				nx_rad = {nx_rad[61:0], 2'b00};
				if (nx_rem >= {2'b00, nx_root, 2'b01}) begin
					nx_rem  = nx_rem - {2'b00, nx_root, 2'b01};
					nx_root = {nx_root[30:0], 1'b1};
				end else begin
					nx_root = {nx_root[30:0], 1'b0};
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[g] <= 1'b0;
			else if (en) vld_s[g] <= src_vld;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[g]  <= src_ctx;
				rad_s[g]  <= nx_rad;
				rem_s[g]  <= nx_rem;
				root_s[g] <= nx_root;
			end
		end
	end

	// Magnitude and distance take their scalar result here.
	always_comb begin
		out_ctx = ctx_s[SQ_STAGES-1];
		if ((out_ctx.cmd == CMD_MAG || out_ctx.cmd == CMD_DIST) && !out_ctx.sat) begin
			if (root_s[SQ_STAGES-1][31]) begin
				out_ctx.sca = Q_MAX;
				out_ctx.sat = 1'b1;
			end else begin
				out_ctx.sca = root_s[SQ_STAGES-1];
			end
		end
	end

	assign out_vld  = vld_s[SQ_STAGES-1];
	assign out_root = root_s[SQ_STAGES-1];

	// A nonzero vector always has a root of at least one, so normalizing never divides by zero.
	`V3A_CHECK(a_norm_root, ((out_vld && out_ctx.cmd == CMD_NORM && !out_ctx.zv) |-> (out_root != 32'd0)), "norm of nonzero vector reached the divider with a zero root")

endmodule

### rtl/v3a_div.sv
module v3a_div import v3a_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  ctx_t             in_ctx,
	input  logic [31:0]      in_root,
	output logic             out_vld,
	output ctx_t             out_ctx,
	output logic [2:0][47:0] out_q
);

	function automatic logic [31:0] abs32(input logic [31:0] v);
		return v[31] ? (~v + 32'd1) : v;
	endfunction

	logic        vld_s [DV_STAGES];
	ctx_t        ctx_s [DV_STAGES];
	logic [31:0] dvs_s [DV_STAGES];
	logic [47:0] nq_s  [DV_STAGES][3];
	logic [31:0] rem_s [DV_STAGES][3];

	for (genvar g = 0; g < DV_STAGES; g++) begin : g_stage
		logic        src_vld;
		ctx_t        src_ctx;
		logic [31:0] src_dvs;
		logic [47:0] src_nq [3];
		logic [31:0] src_rem [3];
		logic [47:0] nx_nq [3];
		logic [31:0] nx_rem [3];
		logic [32:0] r [3];

		if (g == 0) begin : g_first
			assign src_vld = in_vld;
			assign src_ctx = in_ctx;
			assign src_dvs = (in_ctx.cmd == CMD_NORM) ? in_root : abs32(in_ctx.s);
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign src_nq[i]  = {abs32(in_ctx.a[i]), 16'h0000};
				assign src_rem[i] = '0;
			end
		end else begin : g_next
			assign src_vld = vld_s[g-1];
			assign src_ctx = ctx_s[g-1];
			assign src_dvs = dvs_s[g-1];
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign src_nq[i]  = nq_s[g-1][i];
				assign src_rem[i] = rem_s[g-1][i];
			end
		end

		// Restoring division: dividend bits shift out of nq as quotient bits shift in.
		always_comb begin
			for (int i = 0; i < 3; i++) begin
				nx_nq[i]  = src_nq[i];
				nx_rem[i] = src_rem[i];
				r[i]      = '0;
				for (int k = 0; k < DV_STEPS; k++) begin
					r[i] = {nx_rem[i], nx_nq[i][47]};
					if (r[i] >= {1'b0, src_dvs}) begin
						r[i]     = r[i] - {1'b0, src_dvs};
						nx_nq[i] = {nx_nq[i][46:0], 1'b1};
					end else begin
						nx_nq[i] = {nx_nq[i][46:0], 1'b0};
					end
					nx_rem[i] = r[i][31:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[g] <= 1'b0;
			else if (en) vld_s[g] <= src_vld;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				ctx_s[g] <= src_ctx;
				dvs_s[g] <= src_dvs;
				for (int i = 0; i < 3; i++) begin
					nq_s[g][i]  <= nx_nq[i];
					rem_s[g][i] <= nx_rem[i];
				end
			end
		end
	end

	assign out_vld = vld_s[DV_STAGES-1];
	assign out_ctx = ctx_s[DV_STAGES-1];
	for (genvar i = 0; i < 3; i++) begin : g_out
		assign out_q[i] = nq_s[DV_STAGES-1][i];
	end

endmodule

### rtl/vector3_alu.sv
// Three-component vector unit in signed Q16.16. Every command (add, sub, mulv, scale,
// div, mag, magsq, dist, distsq, norm, dot, cross) runs through the same 24-stage
// pipeline. One transfer per cycle is sustained in both directions while the
// consumer does not stall. The depth is set by the chain the slowest command
// needs: three stages for operand select, the 32x32 multipliers and rounding,
// eight for the square root (four root bits per stage), twelve for the three-lane
// divider (four quotient bits per stage) and the output register. The pipeline
// advances as a whole; it holds only while a result sits in the output register and
// the consumer stalls, and it keeps accepting while that register is empty.
// Out-of-range results clamp and report status 1, a zero divisor reports 2, and
// normalizing a zero vector returns it unchanged with status 3. Unknown commands
// give all-zero results with status 0.
`include "vector3_alu_assert.svh"

module vector3_alu import v3a_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  command,
	input  logic [31:0] a_x,
	input  logic [31:0] a_y,
	input  logic [31:0] a_z,
	input  logic [31:0] b_x,
	input  logic [31:0] b_y,
	input  logic [31:0] b_z,
	input  logic [31:0] scalar,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_x,
	output logic [31:0] result_y,
	output logic [31:0] result_z,
	output logic [31:0] result_scalar,
	output logic [1:0]  status
);

	// The whole pipeline moves unless a finished result is waiting on the consumer.
	logic en;
	logic out_valid_q;

	assign in_stall  = out_valid_q && out_stall;
	assign en        = !in_stall;
	assign out_valid = out_valid_q;

	vec_t a_in, b_in;
	assign a_in = {a_z, a_y, a_x};
	assign b_in = {b_z, b_y, b_x};

	// Products, sums of products and the sum of squares.
	logic        pr_vld;
	ctx_t        pr_ctx;
	logic [63:0] pr_sumsq;

	v3a_prod u_prod (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_vld    (in_valid),
		.cmd       (command),
		.a         (a_in),
		.b         (b_in),
		.s         (scalar),
		.out_vld   (pr_vld),
		.out_ctx   (pr_ctx),
		.out_sumsq (pr_sumsq)
	);

	// Floor square root of the sum of squares, for mag, dist and norm.
	logic        sq_vld;
	ctx_t        sq_ctx;
	logic [31:0] sq_root;

	v3a_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (pr_vld),
		.in_ctx   (pr_ctx),
		.in_rad   (pr_sumsq),
		.out_vld  (sq_vld),
		.out_ctx  (sq_ctx),
		.out_root (sq_root)
	);

	// Magnitude quotients |A| * 2^16 / divisor, where the divisor is |S| or the root.
	logic             dv_vld;
	ctx_t             dv_ctx;
	logic [2:0][47:0] dv_q;

	v3a_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sq_vld),
		.in_ctx  (sq_ctx),
		.in_root (sq_root),
		.out_vld (dv_vld),
		.out_ctx (dv_ctx),
		.out_q   (dv_q)
	);

	// Final stage: apply the quotient sign, clamp, and settle the status code.
	vec_t        lane_v;
	logic [2:0]  lane_sat;
	logic [2:0]  neg;
	vec_t        res_v;
	logic [31:0] res_sca;
	logic        res_sat;
	logic [1:0]  res_st;

	always_comb begin
		res_v   = dv_ctx.v;
		res_sca = dv_ctx.sca;
		res_sat = dv_ctx.sat;
		res_st  = ST_OK;
		for (int i = 0; i < 3; i++) begin
			neg[i] = dv_ctx.a[i][31] ^ (dv_ctx.cmd == CMD_DIV && dv_ctx.s[31]);
			if (neg[i]) begin
				lane_sat[i] = dv_q[i] > 48'h0000_8000_0000;
				lane_v[i]   = lane_sat[i] ? Q_MIN : (~dv_q[i][31:0] + 32'd1);
			end else begin
				lane_sat[i] = dv_q[i] > 48'h0000_7fff_ffff;
				lane_v[i]   = lane_sat[i] ? Q_MAX : dv_q[i][31:0];
			end
		end

		if (dv_ctx.cmd == CMD_DIV) begin
			if (dv_ctx.s == 32'd0) begin
				// Zero divisor: the sign of each component picks the rail, and a zero component gives zero.
				for (int i = 0; i < 3; i++) begin
					if (dv_ctx.a[i][31])
						res_v[i] = Q_MIN;
					else if (dv_ctx.a[i] != 32'd0)
						res_v[i] = Q_MAX;
					else
						res_v[i] = '0;
				end
				res_st = ST_DIVZ;
			end else begin
				res_v   = lane_v;
				res_sat = |lane_sat;
			end
		end else if (dv_ctx.cmd == CMD_NORM) begin
			if (dv_ctx.zv) begin
				res_v  = dv_ctx.a;
				res_st = ST_ZERO;
			end else begin
				res_v   = lane_v;
				res_sat = |lane_sat;
			end
		end

		if (res_st == ST_OK && res_sat) res_st = ST_SAT;
	end

	vec_t        res_v_q;
	logic [31:0] res_sca_q;
	logic [1:0]  res_st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (en) out_valid_q <= dv_vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_v_q   <= res_v;
			res_sca_q <= res_sca;
			res_st_q  <= res_st;
		end
	end

	assign result_x      = res_v_q[0];
	assign result_y      = res_v_q[1];
	assign result_z      = res_v_q[2];
	assign result_scalar = res_sca_q;
	assign status        = res_st_q;

	`V3A_CHECK_RST(a_rst_idle, ((!arst_n) |=> (!out_valid)), "result presented during reset")
	`V3A_CHECK(a_div_to_out, ((dv_vld && en) |=> out_valid), "item leaving the divider was lost")
	`V3A_CHECK(a_flag_scalar, ((out_valid && (status == ST_DIVZ || status == ST_ZERO)) |-> (result_scalar == 32'd0)), "vector-only status with nonzero scalar result")

endmodule
